/* sv/sem_pkg.sv */
`default_nettype none
package sem_pkg;

  // largest line length the line store is built for, and largest frame height
  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 2048;

  // register values after reset
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // input kinds carried on tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int PIX_W = 8;
  localparam int SUM_W = 10;

  // grey = sum / 3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int GREY_RECIP = 683;
  localparam int GREY_SHIFT = 11;
  localparam int PROD_W     = 20;

  localparam int QUEUE_DEPTH = 4;

  // one queued transaction, the column travels beside it
  typedef struct packed {
    logic              pixel;
    logic              emit;
    logic [SUM_W-1:0]  sum;
  } item_t;

endpackage
`default_nettype wire

/* sv/sobel_edge_magnitude.sv */
// a result passes the queue, the s2 and s3 registers, then the output register
// one transaction per cycle while not stalled; one line store read and one write per pixel
// a 4-entry queue separates input acceptance from the line store and gradient pipeline
// reset: after rst the line store is zeroed column by column with s_tready low;
// config writes are taken throughout and restart the frame position
`default_nettype none
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [23:0]            s_tdata,   // red, green, blue
  input  wire logic                   s_tuser,   // operation
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,   // magnitude
  output logic                        m_tuser,   // end_of_frame
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RESET_W_LAST = ((RESET_WIDTH  < MAX_WIDTH)  ? RESET_WIDTH  : MAX_WIDTH)  - 1;
  localparam int RESET_H_LAST = ((RESET_HEIGHT < MAX_HEIGHT) ? RESET_HEIGHT : MAX_HEIGHT) - 1;
  localparam int QW = 1 + 1 + SUM_W + CW;

  logic          restart;
  logic [31:0]   cfg_value;
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [CW-1:0] width_last_next;
  logic [RW-1:0] height_last_next;
  logic          clearing;

  logic          push_valid;
  logic          push_ready;
  item_t         push_item;
  logic [CW-1:0] push_col;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;
  item_t         pop_item;
  logic [CW-1:0] pop_col;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;
  assign cfg_value = 32'(cfg_data);

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (cfg_value == '0)                   width_last_next = '0;
    else if (cfg_value > 32'(MAX_WIDTH))   width_last_next = CW'(MAX_WIDTH - 1);
    else                                   width_last_next = CW'(cfg_value - 32'd1);
    if (cfg_value == '0)                   height_last_next = '0;
    else if (cfg_value > 32'(MAX_HEIGHT))  height_last_next = RW'(MAX_HEIGHT - 1);
    else                                   height_last_next = RW'(cfg_value - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= CW'(RESET_W_LAST);
      height_last <= RW'(RESET_H_LAST);
    end else if (restart) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_last  <= width_last_next;
        REG_FRAME_HEIGHT: height_last <= height_last_next;
        default:          width_last  <= width_last;
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .clearing    (clearing),
    .width_last  (width_last),
    .height_last (height_last),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item),
    .push_col    (push_col)
  );

  sem_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_col, push_item}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_item = pop_data[QW-CW-1:0];
  assign pop_col  = pop_data[QW-1:QW-CW];

  sem_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .width_last  (width_last),
    .height_last (height_last),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .pop_col     (pop_col),
    .clearing    (clearing),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

/* sv/sem_front.sv */
`default_nettype none
module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int BW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          restart,
  input  wire logic          clearing,
  input  wire logic [CW-1:0] width_last,
  input  wire logic [RW-1:0] height_last,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [23:0]   s_tdata,   // red, green, blue
  input  wire logic          s_tuser,   // operation
  output logic               push_valid,
  input  wire logic          push_ready,
  output item_t              push_item,
  output logic [CW-1:0]      push_col
);

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [BW-1:0] backlog;
  logic          accept;
  logic          at_start;
  logic          full_backlog;

  assign s_tready     = push_ready && !clearing;
  assign accept       = s_tvalid && s_tready;
  assign at_start     = (in_col == '0) && (in_row == '0);
  assign full_backlog = backlog == (BW'(width_last) + BW'(1));

  always_comb begin
    push_item.pixel = (s_tuser == OP_PIXEL);
    push_item.sum   = SUM_W'(s_tdata[7:0]) + SUM_W'(s_tdata[15:8]) + SUM_W'(s_tdata[23:16]);
    push_col        = in_col;
    if (s_tuser == OP_PIXEL) begin
      push_item.emit = full_backlog;
      push_valid     = accept;
    end else begin
      // a drain only counts once the frame has fully arrived
      push_item.emit = at_start && (backlog != '0);
      push_valid     = accept && at_start && (backlog != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      backlog <= '0;
    end else if (accept) begin
      if (s_tuser == OP_PIXEL) begin
        if (!full_backlog) backlog <= backlog + BW'(1);
        if (in_col == width_last) begin
          in_col <= '0;
          in_row <= (in_row == height_last) ? '0 : in_row + RW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end else if (at_start && (backlog != '0)) begin
        backlog <= backlog - BW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/sem_queue.sv */
`default_nettype none
module sem_queue
  import sem_pkg::*;
#(
  parameter int DATA_W = 8,
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int NW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != NW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/sem_back.sv */
`default_nettype none
module sem_back
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          restart,
  input  wire logic [CW-1:0] width_last,
  input  wire logic [RW-1:0] height_last,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire item_t         pop_item,
  input  wire logic [CW-1:0] pop_col,
  output logic               clearing,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,   // magnitude
  output logic               m_tuser    // end_of_frame
);

  // each word holds {two rows up, one row up} for one column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] ram_q;
  logic [2*PIX_W-1:0] byp_data;
  logic               byp;
  logic [2*PIX_W-1:0] lines;

  logic [CW-1:0]      clear_cnt;
  logic               mem_we;
  logic [CW-1:0]      mem_wa;
  logic [2*PIX_W-1:0] mem_wd;

  logic               advance;
  logic [PROD_W-1:0]  grey_prod;

  logic               s2_valid;
  logic               s2_pixel;
  logic               s2_emit;
  logic [PIX_W-1:0]   s2_grey;
  logic [CW-1:0]      s2_col;

  logic [PIX_W-1:0]   win      [3][3];
  logic [PIX_W-1:0]   win_next [3][3];
  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic [9:0]         ax;
  logic [9:0]         ay;

  logic [CW-1:0]      out_col;
  logic [RW-1:0]      out_row;
  logic               last_col;
  logic               last_row;

  logic               s3_valid;
  logic               s3_interior;
  logic               s3_eof;
  logic [9:0]         s3_ax;
  logic [9:0]         s3_ay;
  logic [10:0]        mag_sum;

  assign advance   = !m_tvalid || m_tready;
  assign pop_ready = advance;
  assign grey_prod = PROD_W'(pop_item.sum) * PROD_W'(GREY_RECIP);
  assign lines     = byp ? byp_data : ram_q;

  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clear_cnt;
      mem_wd = '0;
    end else begin
      mem_we = advance && s2_valid && s2_pixel;
      mem_wa = s2_col;
      mem_wd = {lines[PIX_W-1:0], s2_grey};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ram_q    <= line_mem[pop_col];
      // same column written in this cycle: take the new word
      byp      <= mem_we && (mem_wa == pop_col);
      byp_data <= mem_wd;
    end
  end

  // zero the line store once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      if (clear_cnt == CW'(MAX_WIDTH - 1)) clearing <= 1'b0;
      else clear_cnt <= clear_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pixel <= pop_item.pixel;
      s2_emit  <= pop_item.emit;
      s2_grey  <= grey_prod[GREY_SHIFT+PIX_W-1:GREY_SHIFT];
      s2_col   <= pop_col;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_next[r][c] = win[r][c];
      end
    end
    if (s2_valid && s2_pixel) begin
      for (int r = 0; r < 3; r++) begin
        win_next[r][0] = win[r][1];
        win_next[r][1] = win[r][2];
      end
      win_next[0][2] = lines[2*PIX_W-1:PIX_W];
      win_next[1][2] = lines[PIX_W-1:0];
      win_next[2][2] = s2_grey;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (advance) begin
      win <= win_next;
    end
  end

  always_comb begin
    gx = (12'(win_next[0][2]) + {3'b0, win_next[1][2], 1'b0} + 12'(win_next[2][2]))
       - (12'(win_next[0][0]) + {3'b0, win_next[1][0], 1'b0} + 12'(win_next[2][0]));
    gy = (12'(win_next[0][0]) + {3'b0, win_next[0][1], 1'b0} + 12'(win_next[0][2]))
       - (12'(win_next[2][0]) + {3'b0, win_next[2][1], 1'b0} + 12'(win_next[2][2]));
    ax = gx[11] ? 10'(-gx) : 10'(gx);
    ay = gy[11] ? 10'(-gy) : 10'(gy);
  end

  assign last_col = out_col == width_last;
  assign last_row = out_row == height_last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_col <= '0;
      out_row <= '0;
    end else if (advance && s2_valid && s2_emit) begin
      if (last_col) begin
        out_col <= '0;
        out_row <= last_row ? '0 : out_row + RW'(1);
      end else begin
        out_col <= out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ax       <= ax;
      s3_ay       <= ay;
      s3_eof      <= last_row && last_col;
      s3_interior <= (out_row != '0) && !last_row && (out_col != '0) && !last_col;
    end
  end

  assign mag_sum = 11'(s3_ax) + 11'(s3_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!s3_interior)         m_tdata <= '0;
      else if (mag_sum > 11'd255) m_tdata <= 8'd255;
      else                        m_tdata <= mag_sum[7:0];
      m_tuser <= s3_eof;
    end
  end

endmodule
`default_nettype wire
